[hdl/grid_line_of_sight_checker_defines.svh]
// ----------------------------------------------------------------------------
// grid line-of-sight checker assertion macros
// shared property forms for the checker's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OF_SIGHT_CHECKER_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_CHECKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GLC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glc assertion failed");

// consequent must hold in the cycle after the antecedent
`define GLC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glc assertion failed");

`endif

[hdl/glc_pkg.sv]
// ----------------------------------------------------------------------------
// glc_pkg
// field widths, codes, defaults and shared types of the line-of-sight checker
// ----------------------------------------------------------------------------
package glc_pkg;

	// request field widths
	localparam int CELL_FW = 5;
	localparam int OFF_FW  = 8;
	localparam int WALL_FW = 4;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// wall bit positions
	localparam int WALL_N = 0;
	localparam int WALL_E = 1;
	localparam int WALL_S = 2;
	localparam int WALL_W = 3;

	// default geometry
	localparam int DEF_GRID_COLS = 32;
	localparam int DEF_GRID_ROWS = 32;
	localparam int DEF_CELL_W    = 192;
	localparam int DEF_CELL_H    = 192;

	// wall map access controls
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

	// walk outcome handed to the output register
	typedef struct packed {
		logic done;
		logic clear;
	} walk_res_t;

endpackage

[hdl/glc_wall_mem.sv]
// ----------------------------------------------------------------------------
// glc_wall_mem
// single-port wall map with registered read and a clearing sweep after reset
// ----------------------------------------------------------------------------
module glc_wall_mem #(
	parameter int MAP_CELLS = 1024,
	parameter int ADDR_W    = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  glc_pkg::mem_ctl_t            ctl,
	input  logic [ADDR_W-1:0]            addr,
	input  logic [glc_pkg::WALL_FW-1:0]  wdata,
	output logic [glc_pkg::WALL_FW-1:0]  rdata,
	output logic                         busy
);
	import glc_pkg::*;

	logic [WALL_FW-1:0] mem_q [MAP_CELLS];
	logic [WALL_FW-1:0] rdata_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               clearing_q;

	// clearing sweep, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(MAP_CELLS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// storage, write then registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clearing_q;

endmodule

[hdl/glc_walker.sv]
// ----------------------------------------------------------------------------
// glc_walker
// request decode, wall writes and the cell-by-cell walk of a line query
// ----------------------------------------------------------------------------
`include "grid_line_of_sight_checker_defines.svh"

module glc_walker #(
	parameter int GRID_COLS = 32,
	parameter int GRID_ROWS = 32,
	parameter int CELL_W    = 192,
	parameter int CELL_H    = 192,
	parameter int ADDR_W    = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [glc_pkg::CELL_FW-1:0]  start_cell_x,
	input  logic [glc_pkg::CELL_FW-1:0]  start_cell_y,
	input  logic [glc_pkg::OFF_FW-1:0]   start_off_x,
	input  logic [glc_pkg::OFF_FW-1:0]   start_off_y,
	input  logic [glc_pkg::CELL_FW-1:0]  finish_cell_x,
	input  logic [glc_pkg::CELL_FW-1:0]  finish_cell_y,
	input  logic [glc_pkg::OFF_FW-1:0]   finish_off_x,
	input  logic [glc_pkg::OFF_FW-1:0]   finish_off_y,
	input  logic [glc_pkg::WALL_FW-1:0]  wall_bits,
	input  logic                         mem_busy,
	output glc_pkg::mem_ctl_t            mem_ctl,
	output logic [ADDR_W-1:0]            mem_addr,
	output logic [glc_pkg::WALL_FW-1:0]  mem_wdata,
	input  logic [glc_pkg::WALL_FW-1:0]  mem_rdata,
	input  logic                         out_free,
	output glc_pkg::walk_res_t           res
);
	import glc_pkg::*;

	// point coordinate widths
	localparam int MAX_PX = ((2 ** CELL_FW) - 1) * CELL_W + (2 ** OFF_FW) - 1;
	localparam int MAX_PY = ((2 ** CELL_FW) - 1) * CELL_H + (2 ** OFF_FW) - 1;
	localparam int MAX_P  = (MAX_PX > MAX_PY) ? MAX_PX : MAX_PY;
	localparam int POS_W  = $clog2(MAX_P + 1);
	localparam int SW     = POS_W + 2;
	localparam int PW     = 2 * SW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_WALK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CELL_FW-1:0]    tx_q, ty_q, fx_q, fy_q;
	logic                  east_q, south_q, clear_q;
	logic signed [SW-1:0]  dx_q, dy_q, lx_q, ly_q;
	logic signed [PW-1:0]  prod_a_q, prod_b_q;

	logic [CELL_FW-1:0]    sx, sy, fx, fy;
	logic [POS_W-1:0]      px0, py0, px1, py1;
	logic                  east, south;
	logic                  accept, reach_x, reach_y, step_y, wall_hit;
	logic [CELL_FW-1:0]    tx_n, ty_n;

	function automatic logic [CELL_FW-1:0] sat_col(input logic [CELL_FW-1:0] v);
		return (int'(v) >= GRID_COLS) ? CELL_FW'(GRID_COLS - 1) : v;
	endfunction

	function automatic logic [CELL_FW-1:0] sat_row(input logic [CELL_FW-1:0] v);
		return (int'(v) >= GRID_ROWS) ? CELL_FW'(GRID_ROWS - 1) : v;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_FW-1:0] col,
			input logic [CELL_FW-1:0] row);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(GRID_COLS) + ADDR_W'(col));
	endfunction

	// request decode and absolute points
	assign sx    = sat_col(start_cell_x);
	assign sy    = sat_row(start_cell_y);
	assign fx    = sat_col(finish_cell_x);
	assign fy    = sat_row(finish_cell_y);
	assign px0   = POS_W'(sx) * POS_W'(CELL_W) + POS_W'(start_off_x);
	assign py0   = POS_W'(sy) * POS_W'(CELL_H) + POS_W'(start_off_y);
	assign px1   = POS_W'(fx) * POS_W'(CELL_W) + POS_W'(finish_off_x);
	assign py1   = POS_W'(fy) * POS_W'(CELL_H) + POS_W'(finish_off_y);
	assign east  = fx > sx;
	assign south = fy > sy;

	assign in_stall = (state_q != S_IDLE) || mem_busy;
	assign accept   = in_valid && !in_stall;

	// wall map port: writes from idle, walk reads from the read state
	always_comb begin
		mem_ctl.wr = accept && (op == OP_WRITE);
		mem_ctl.rd = (state_q == S_READ);
		mem_wdata  = wall_bits;
		mem_addr   = (state_q == S_READ) ? cell_addr(tx_q, ty_q) : cell_addr(sx, sy);
	end

	// step choice from the registered slope products
	always_comb begin
		reach_x = (tx_q == fx_q);
		reach_y = (ty_q == fy_q);
		if (reach_x) begin
			step_y = 1'b1;
		end else if (reach_y) begin
			step_y = 1'b0;
		end else if (east_q) begin
			step_y = south_q ? (prod_a_q < prod_b_q) : (prod_a_q > prod_b_q);
		end else begin
			step_y = south_q ? (prod_a_q >= prod_b_q) : (prod_a_q < prod_b_q);
		end
		if (step_y) begin
			wall_hit = south_q ? mem_rdata[WALL_S] : mem_rdata[WALL_N];
			tx_n     = tx_q;
			ty_n     = south_q ? ty_q + 1'b1 : ty_q - 1'b1;
		end else begin
			wall_hit = east_q ? mem_rdata[WALL_E] : mem_rdata[WALL_W];
			tx_n     = east_q ? tx_q + 1'b1 : tx_q - 1'b1;
			ty_n     = ty_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_QUERY)) begin
						state_q <= ((sx == fx) && (sy == fy)) ? S_DONE : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (wall_hit || ((tx_n == fx_q) && (ty_n == fy_q))) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (accept && (op == OP_QUERY)) begin
			tx_q    <= sx;
			ty_q    <= sy;
			fx_q    <= fx;
			fy_q    <= fy;
			east_q  <= east;
			south_q <= south;
			clear_q <= 1'b1;
			dx_q    <= $signed(SW'(px1)) - $signed(SW'(px0));
			dy_q    <= $signed(SW'(py1)) - $signed(SW'(py0));
			lx_q    <= $signed((east ? SW'(CELL_W) : SW'(0)) - SW'(start_off_x));
			ly_q    <= $signed((south ? SW'(CELL_H) : SW'(0)) - SW'(start_off_y));
		end
		if (state_q == S_READ) begin
			prod_a_q <= ly_q * dx_q;
			prod_b_q <= dy_q * lx_q;
		end
		if (state_q == S_WALK) begin
			if (wall_hit) begin
				clear_q <= 1'b0;
			end else begin
				tx_q <= tx_n;
				ty_q <= ty_n;
				if (step_y) begin
					ly_q <= south_q ? ly_q + SW'(CELL_H) : ly_q - SW'(CELL_H);
				end else begin
					lx_q <= east_q ? lx_q + SW'(CELL_W) : lx_q - SW'(CELL_W);
				end
			end
		end
	end

	assign res.done  = (state_q == S_DONE) && out_free;
	assign res.clear = clear_q;

	// checks
	`GLC_ASSERT_NOW(a_no_overshoot, state_q == S_READ, (tx_q != fx_q) || (ty_q != fy_q))
	`GLC_ASSERT_NOW(a_write_when_idle, mem_ctl.wr, !mem_busy && (state_q == S_IDLE))
	`GLC_ASSERT_NEXT(a_one_axis_step, (state_q == S_WALK) && !wall_hit, (tx_q != $past(tx_q)) != (ty_q != $past(ty_q)))

endmodule

[hdl/grid_line_of_sight_checker.sv]
// a wall write gives no result; a query crossing n cell boundaries (n up to 62)
// steps through them one at a time and stops at a wall, and the next request is
// taken only once its result has gone into the output register
// each step costs one wall map read and one registered pair of slope products
// after reset a sweep clears all GRID_COLS*GRID_ROWS cells (1024 by default) of the
// wall map, with in_stall high throughout
// ----------------------------------------------------------------------------
// grid_line_of_sight_checker
// wall map per grid cell with line-of-sight queries walked one cell at a time
// ----------------------------------------------------------------------------
module grid_line_of_sight_checker #(
	parameter int GRID_COLS = glc_pkg::DEF_GRID_COLS,
	parameter int GRID_ROWS = glc_pkg::DEF_GRID_ROWS,
	parameter int CELL_W    = glc_pkg::DEF_CELL_W,
	parameter int CELL_H    = glc_pkg::DEF_CELL_H
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [glc_pkg::CELL_FW-1:0]  start_cell_x,
	input  logic [glc_pkg::CELL_FW-1:0]  start_cell_y,
	input  logic [glc_pkg::OFF_FW-1:0]   start_off_x,
	input  logic [glc_pkg::OFF_FW-1:0]   start_off_y,
	input  logic [glc_pkg::CELL_FW-1:0]  finish_cell_x,
	input  logic [glc_pkg::CELL_FW-1:0]  finish_cell_y,
	input  logic [glc_pkg::OFF_FW-1:0]   finish_off_x,
	input  logic [glc_pkg::OFF_FW-1:0]   finish_off_y,
	input  logic [glc_pkg::WALL_FW-1:0]  wall_bits,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         path_clear
);
	import glc_pkg::*;

	localparam int MAP_CELLS = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W    = $clog2(MAP_CELLS);

	mem_ctl_t            mem_ctl;
	logic [ADDR_W-1:0]   mem_addr;
	logic [WALL_FW-1:0]  mem_wdata, mem_rdata;
	logic                mem_busy;
	walk_res_t           res;
	logic                out_valid_q, path_clear_q, out_free;

	glc_wall_mem #(
		.MAP_CELLS (MAP_CELLS),
		.ADDR_W    (ADDR_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	glc_walker #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS),
		.CELL_W    (CELL_W),
		.CELL_H    (CELL_H),
		.ADDR_W    (ADDR_W)
	) u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.start_cell_x  (start_cell_x),
		.start_cell_y  (start_cell_y),
		.start_off_x   (start_off_x),
		.start_off_y   (start_off_y),
		.finish_cell_x (finish_cell_x),
		.finish_cell_y (finish_cell_y),
		.finish_off_x  (finish_off_x),
		.finish_off_y  (finish_off_y),
		.wall_bits     (wall_bits),
		.mem_busy      (mem_busy),
		.mem_ctl       (mem_ctl),
		.mem_addr      (mem_addr),
		.mem_wdata     (mem_wdata),
		.mem_rdata     (mem_rdata),
		.out_free      (out_free),
		.res           (res)
	);

	// output register, free when empty or being taken
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			path_clear_q <= res.clear;
		end
	end

	assign out_valid  = out_valid_q;
	assign path_clear = path_clear_q;

endmodule
